// ----- hw/rtl/mlp_pkg.sv -----
`default_nettype none
package mlp_pkg;
  localparam int unsigned N_INPUTS_DEF  = 3;
  localparam int unsigned N_HIDDEN_DEF  = 64;
  localparam int unsigned N_OUTPUTS_DEF = 1;
  localparam int unsigned ADDR_W = 13;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned DRV_W  = 14;
  localparam int unsigned OIDX_W = 3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_OBS   = 1'b1;

  localparam logic [1:0] LYR_FIRST  = 2'd0;
  localparam logic [1:0] LYR_SECOND = 2'd1;
  localparam logic [1:0] LYR_OUT    = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       acc_init;   // load bias into accumulator
    logic       acc_mac;    // add product of operands
    logic       acc_done;   // round, saturate and store neuron
    logic [1:0] layer;      // first, second or output layer
  } mlp_cmd_t;

  function automatic logic signed [DRV_W-1:0] tanh_q12(input logic signed [VAL_W-1:0] x);
    logic [VAL_W:0] m;
    logic [5:0]     k;
    logic [9:0]     f;
    logic [12:0]    t0;
    logic [12:0]    t1;
    logic [23:0]    prod;
    logic [12:0]    y;
    logic [12:0]    knots [0:20];
    begin
      knots = '{13'd0, 13'd1003, 13'd1893, 13'd2602, 13'd3119, 13'd3475, 13'd3707,
                13'd3856, 13'd3949, 13'd4006, 13'd4041, 13'd4062, 13'd4076, 13'd4084,
                13'd4089, 13'd4091, 13'd4093, 13'd4094, 13'd4095, 13'd4095, 13'd4096};
      m = x[VAL_W-1] ? (VAL_W+1)'(-{x[VAL_W-1], x}) : {1'b0, x};
      k = m[15:10];
      f = m[9:0];
      if (k >= 6'd20) begin
        y = 13'd4096;
      end else begin
        t0 = knots[k[4:0]];
        t1 = knots[5'(k[4:0] + 5'd1)];
        prod = 24'(t1 - t0) * 24'(f) + 24'd512;
        y = 13'(t0 + 13'(prod >> 10));
      end
      tanh_q12 = x[VAL_W-1] ? -$signed({1'b0, y}) : $signed({1'b0, y});
    end
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/mlp_ram.sv -----
`default_nettype none
module mlp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mlp_datapath.sv -----
`default_nettype none
module mlp_datapath (
  input  wire logic                              clk,
  input  wire mlp_pkg::mlp_cmd_t                 cmd,
  input  wire logic signed [mlp_pkg::VAL_W-1:0]  weight,   // from store, registered
  input  wire logic signed [mlp_pkg::VAL_W-1:0]  operand,  // activation, registered
  output logic signed [mlp_pkg::VAL_W-1:0]       neuron_q, // relu or raw result
  output logic signed [mlp_pkg::DRV_W-1:0]       drive
);
  import mlp_pkg::*;

  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] prod_r;
  logic               prod_v_r;
  logic signed [33:0] sum;
  logic signed [33:0] rnd;
  logic signed [21:0] sh;
  logic signed [VAL_W-1:0] q;

  assign sum = 34'(acc_r) + 34'(prod_r);
  always_comb begin
    acc_nxt = acc_r;
    if (prod_v_r) begin
      if (sum > 34'sd2147483647) acc_nxt = 32'sh7fffffff;
      else if (sum < -34'sd2147483648) acc_nxt = 32'sh80000000;
      else acc_nxt = sum[31:0];
    end
    if (cmd.acc_init) acc_nxt = {{4{weight[VAL_W-1]}}, weight, 12'd0};
  end

  // rounding to q4.12 with saturation
  assign rnd = 34'(acc_r) + 34'sd2048;
  assign sh  = rnd[33:12];
  always_comb begin
    if (sh > 22'sd32767) q = 16'sh7fff;
    else if (sh < -22'sd32768) q = 16'sh8000;
    else q = sh[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    prod_r   <= 32'(weight) * 32'(operand);
    prod_v_r <= cmd.acc_mac;
    acc_r    <= acc_nxt;
    if (cmd.acc_done) begin
      neuron_q <= (cmd.layer != LYR_OUT && q[VAL_W-1]) ? '0 : q;
      drive    <= tanh_q12(q);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mlp_ctrl.sv -----
`default_nettype none
module mlp_ctrl #(
  parameter int unsigned N_INPUTS  = 3,
  parameter int unsigned N_HIDDEN  = 64,
  parameter int unsigned N_OUTPUTS = 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  output mlp_pkg::mlp_cmd_t                 cmd,
  output logic [mlp_pkg::ADDR_W-1:0]        waddr,   // store read address
  output logic [$clog2(N_HIDDEN)-1:0]       jidx,    // operand index
  output logic [$clog2(N_HIDDEN)-1:0]       nidx,    // neuron being written back
  output logic                              wr_h1,
  output logic                              wr_h2,
  output logic                              res_valid,
  output logic [mlp_pkg::OIDX_W-1:0]        res_idx,
  input  wire logic                         res_taken
);
  import mlp_pkg::*;

  localparam int unsigned OFS_B1 = N_HIDDEN * N_INPUTS;
  localparam int unsigned OFS_W2 = OFS_B1 + N_HIDDEN;
  localparam int unsigned OFS_B2 = OFS_W2 + N_HIDDEN * N_HIDDEN;
  localparam int unsigned OFS_W3 = OFS_B2 + N_HIDDEN;
  localparam int unsigned OFS_B3 = OFS_W3 + N_OUTPUTS * N_HIDDEN;
  localparam int unsigned HW = $clog2(N_HIDDEN);

  typedef enum logic [2:0] {S_IDLE, S_BIAS, S_MAC, S_DRAIN, S_DONE, S_OUT} state_t;

  state_t state_r;
  logic [1:0]        layer_r;
  logic [HW:0]       n_r;      // neuron counter
  logic [HW:0]       j_r;      // operand counter
  logic [HW:0]       nlen, jlen;
  logic [2:0]        dr_r;
  logic [ADDR_W-1:0] wbase, bbase;

  always_comb begin
    unique case (layer_r)
      LYR_FIRST:  begin nlen = (HW+1)'(N_HIDDEN); jlen = (HW+1)'(N_INPUTS); end
      LYR_SECOND: begin nlen = (HW+1)'(N_HIDDEN); jlen = (HW+1)'(N_HIDDEN); end
      default:    begin nlen = (HW+1)'(N_OUTPUTS); jlen = (HW+1)'(N_HIDDEN); end
    endcase
    unique case (layer_r)
      LYR_FIRST:  begin wbase = '0; bbase = ADDR_W'(OFS_B1); end
      LYR_SECOND: begin wbase = ADDR_W'(OFS_W2); bbase = ADDR_W'(OFS_B2); end
      default:    begin wbase = ADDR_W'(OFS_W3); bbase = ADDR_W'(OFS_B3); end
    endcase
  end

  // bias address held throughout the bias state so it is on the read port
  // when the accumulator loads; each weight address is issued in the cycle before use
  always_comb begin
    if (state_r == S_IDLE || state_r == S_BIAS) begin
      waddr = ADDR_W'(bbase + ADDR_W'(n_r));
    end else begin
      waddr = ADDR_W'(wbase + ADDR_W'(n_r) * ADDR_W'(jlen) + ADDR_W'(j_r));
    end
  end

  assign busy  = state_r != S_IDLE;
  assign jidx  = j_r[HW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      layer_r   <= LYR_FIRST;
      n_r       <= '0;
      j_r       <= '0;
      dr_r      <= '0;
      cmd       <= '0;
      wr_h1     <= 1'b0;
      wr_h2     <= 1'b0;
      nidx      <= '0;
      res_valid <= 1'b0;
      res_idx   <= '0;
    end else begin
      cmd.acc_init <= state_r == S_BIAS && dr_r == 3'd1;
      cmd.acc_mac  <= state_r == S_MAC;
      cmd.acc_done <= state_r == S_DRAIN && dr_r == 3'd3;
      cmd.layer    <= layer_r;
      wr_h1 <= state_r == S_DONE && layer_r == LYR_FIRST;
      wr_h2 <= state_r == S_DONE && layer_r == LYR_SECOND;
      // write-back index is registered from the neuron counter, so it trails it like the result
      nidx  <= n_r[HW-1:0];
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            layer_r <= LYR_FIRST;
            n_r     <= '0;
            j_r     <= '0;
            dr_r    <= '0;
            state_r <= S_BIAS;
          end
        end
        S_BIAS: begin
          if (dr_r == 3'd1) begin
            dr_r    <= '0;
            state_r <= S_MAC;
          end else begin
            dr_r <= 3'd1;
          end
        end
        S_MAC: begin
          // address j presented; weight and operand valid next cycle
          if (j_r == jlen - 1'b1) begin
            j_r     <= '0;
            dr_r    <= '0;
            state_r <= S_DRAIN;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_DRAIN: begin
          dr_r <= dr_r + 1'b1;
          if (dr_r == 3'd3) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          dr_r <= '0;
          if (layer_r == LYR_OUT) begin
            res_valid <= 1'b1;
            res_idx   <= OIDX_W'(n_r);
            state_r   <= S_OUT;
          end else if (n_r == nlen - 1'b1) begin
            n_r     <= '0;
            layer_r <= layer_r + 1'b1;
            state_r <= S_BIAS;
          end else begin
            n_r     <= n_r + 1'b1;
            state_r <= S_BIAS;
          end
        end
        S_OUT: begin
          if (res_taken) begin
            res_valid <= 1'b0;
            if (n_r == nlen - 1'b1) begin
              state_r <= S_IDLE;
            end else begin
              n_r     <= n_r + 1'b1;
              state_r <= S_BIAS;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mlp_forward_inference_core.sv -----
`default_nettype none
// Three-layer perceptron in signed q4.12: requests either write one weight or
// bias (action 0) or deliver one observation element (action 1). The element at
// index N_INPUTS-1 starts an inference over one shared multiply-accumulate unit
// reading one weight per cycle from the weight store during each neuron's fan-in.
// Each neuron passes through a bias fetch, its fan-in of multiply-accumulates, a
// drain of the multiply-accumulate pipeline and a store of the result. Each output
// result waits on the output handshake before the next neuron starts, so
// out_tready stalls lengthen an inference, and the core returns to idle before
// the next request is taken. Results stream out one per output neuron, tlast on
// the final one. No requests are taken while an inference runs.
module mlp_forward_inference_core #(
  parameter int unsigned N_INPUTS  = mlp_pkg::N_INPUTS_DEF,
  parameter int unsigned N_HIDDEN  = mlp_pkg::N_HIDDEN_DEF,
  parameter int unsigned N_OUTPUTS = mlp_pkg::N_OUTPUTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // param_address, param_value, obs_index, obs_value
  input  wire logic        in_tuser,  // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // drive_value, output_index
  output logic             out_tlast  // last
);
  import mlp_pkg::*;

  localparam int unsigned DEPTH = N_HIDDEN*N_INPUTS + N_HIDDEN + N_HIDDEN*N_HIDDEN
                                  + N_HIDDEN + N_OUTPUTS*N_HIDDEN + N_OUTPUTS;
  localparam int unsigned DW = $clog2(DEPTH);
  localparam int unsigned HW = $clog2(N_HIDDEN);
  localparam int unsigned OW = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;

  logic [ADDR_W-1:0] p_addr;
  logic [VAL_W-1:0]  p_val, o_val;
  logic [IDX_W-1:0]  o_idx;
  logic              acc, busy, start;
  mlp_cmd_t          cmd;
  logic [ADDR_W-1:0] raddr;
  logic [HW-1:0]     jidx, nidx;
  logic              wr_h1, wr_h2, res_valid;
  logic [OIDX_W-1:0] res_idx;
  logic [VAL_W-1:0]  wdata_rd, h1_rd, h2_rd, operand;
  logic [VAL_W-1:0]  obs_r [0:N_INPUTS-1];
  logic [1:0]        layer_d_r;
  logic [HW-1:0]     jidx_d_r;
  logic signed [VAL_W-1:0] neuron_q;
  logic signed [DRV_W-1:0] drive;
  logic              wr_en;

  assign p_addr = in_tdata[12:0];
  assign p_val  = in_tdata[28:13];
  assign o_idx  = in_tdata[30:29];
  assign o_val  = in_tdata[46:31];

  assign in_tready = !busy;
  assign acc   = in_tvalid && in_tready;
  assign wr_en = acc && in_tuser == ACT_WRITE && p_addr < ADDR_W'(DEPTH);
  assign start = acc && in_tuser == ACT_OBS && o_idx == IDX_W'(N_INPUTS - 1);

  always_ff @(posedge clk) begin
    if (acc && in_tuser == ACT_OBS && 32'(o_idx) < N_INPUTS) begin
      obs_r[o_idx] <= o_val;
    end
    jidx_d_r  <= jidx;
    layer_d_r <= cmd.layer;
  end

  mlp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(wr_en), .waddr(p_addr[DW-1:0]), .wdata(p_val),
    .raddr(raddr[DW-1:0]), .rdata(wdata_rd));
  mlp_ram #(.WIDTH(VAL_W), .DEPTH(N_HIDDEN)) u_h1 (
    .clk(clk), .we(wr_h1), .waddr(nidx), .wdata(neuron_q),
    .raddr(jidx), .rdata(h1_rd));
  mlp_ram #(.WIDTH(VAL_W), .DEPTH(N_HIDDEN)) u_h2 (
    .clk(clk), .we(wr_h2), .waddr(nidx), .wdata(neuron_q),
    .raddr(jidx), .rdata(h2_rd));

  // operand select uses a registered copy of cmd.layer, itself a register of the controller's layer
  always_comb begin
    unique case (layer_d_r)
      LYR_FIRST:  operand = obs_r[jidx_d_r[OW-1:0]];
      LYR_SECOND: operand = h1_rd;
      default:    operand = h2_rd;
    endcase
  end

  mlp_ctrl #(.N_INPUTS(N_INPUTS), .N_HIDDEN(N_HIDDEN), .N_OUTPUTS(N_OUTPUTS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
    .waddr(raddr), .jidx(jidx), .nidx(nidx), .wr_h1(wr_h1), .wr_h2(wr_h2),
    .res_valid(res_valid), .res_idx(res_idx), .res_taken(out_tready));

  mlp_datapath u_dp (
    .clk(clk), .cmd(cmd), .weight(wdata_rd), .operand(operand),
    .neuron_q(neuron_q), .drive(drive));

  assign out_tvalid = res_valid;
  assign out_tdata  = {7'd0, res_idx, drive};
  assign out_tlast  = res_idx == OIDX_W'(N_OUTPUTS - 1);
endmodule
`default_nettype wire
